[design/rte_pkg.sv]
// Shared types, constants and codes of the RSSI trilateration engine.
package rte_pkg;

    localparam int POS_W       = 24;
    localparam int UNC_W       = 23;
    localparam int DIST_W      = 23;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 24;
    localparam int NUM_CORNERS = 4;

    localparam int DESCENT_STEPS = 1000;
    localparam int STEP_W        = 16;
    localparam int DIST_ITERS    = 177;
    localparam int SQRT_ITERS    = 25;
    localparam int CNT_W         = 8;

    localparam logic [31:0] K_UP       = 32'd1137365027;
    localparam logic [31:0] K_DOWN     = 32'd1013677647;
    localparam logic [25:0] RECIP3     = 26'd44739243;
    localparam logic [UNC_W-1:0] UNC_MAX = {UNC_W{1'b1}};

    localparam logic [1:0] FIX_FUSED  = 2'd0;
    localparam logic [1:0] FIX_SINGLE = 2'd1;
    localparam logic [1:0] FIX_NONE   = 2'd2;

    typedef struct packed {
        logic [15:0]        tag_id;
        logic [3:0]         present_mask;
        logic signed [7:0]  rssi_a;
        logic signed [7:0]  rssi_b;
        logic signed [7:0]  rssi_c;
        logic signed [7:0]  rssi_d;
    } t_req;

    typedef struct packed {
        logic [15:0]             out_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [UNC_W-1:0]        uncertainty;
        logic [1:0]              fix_kind;
    } t_res;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_DIST_ITER,
        OP_DIST_FIN,
        OP_TRI_LOAD,
        OP_CENT0,
        OP_CENT1,
        OP_SQ,
        OP_SQRT_LOAD,
        OP_SQRT_ITER,
        OP_RES,
        OP_FSQ,
        OP_GRAD,
        OP_LR,
        OP_UPD,
        OP_SAVE,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] triplet;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] tri_ok;
    } t_dp_stat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIST,
        ST_DIST_FIN,
        ST_TRI_SEL,
        ST_TRI_LOAD,
        ST_CENT0,
        ST_CENT1,
        ST_SQ,
        ST_SQRT_LOAD,
        ST_SQRT_ITER,
        ST_RES,
        ST_FSQ,
        ST_GRAD,
        ST_LR,
        ST_UPD,
        ST_SAVE,
        ST_EMIT
    } t_state;

endpackage

[design/rte_datapath.sv]
// Datapath: corner registers, distance lanes, descent arithmetic and result register.
module rte_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rte_pkg::t_dp_cmd              i_cmd,
    input  rte_pkg::t_req                 i_req,
    input  logic                          i_cfg_we,
    input  logic [rte_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rte_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rte_pkg::t_dp_stat             o_stat,
    output rte_pkg::t_res                 o_res,
    output logic                          o_valid
);
    import rte_pkg::*;

    localparam logic signed [8:0]  RSSI_REF = -9'sd50;
    localparam logic signed [55:0] GCLAMP   = 56'sd1 <<< 44;
    localparam logic signed [63:0] LR_Q24   = 64'sd167772;
    localparam logic [63:0]        ROUND24  = 64'd1 << 23;
    localparam logic [63:0]        ROUND30  = 64'd1 << 29;
    localparam logic signed [41:0] SAT_HI   = 42'sd8388607;
    localparam logic signed [41:0] SAT_LO   = -42'sd8388608;

    logic signed [POS_W-1:0] r_corner_x [NUM_CORNERS];
    logic signed [POS_W-1:0] r_corner_y [NUM_CORNERS];
    t_req                    r_req;

    logic [31:0]       r_v    [4];
    logic [7:0]        r_dcnt [4];
    logic              r_dup  [4];
    logic [DIST_W-1:0] r_dist [4];

    logic signed [POS_W-1:0] r_cx [3];
    logic signed [POS_W-1:0] r_cy [3];
    logic [DIST_W-1:0]       r_cd [3];
    logic [1:0]              r_tri;
    logic [1:0]              r_last;

    logic [24:0] r_cmag_x, r_cmag_y;
    logic        r_cneg_x, r_cneg_y;

    logic signed [POS_W-1:0] r_x, r_y;

    logic [49:0] r_sx0 [3];
    logic [49:0] r_sx1 [3];
    logic [49:0] r_sy0 [3];
    logic [49:0] r_sy1 [3];

    logic [49:0] r_rad  [9];
    logic [26:0] r_rem  [9];
    logic [24:0] r_root [9];

    logic signed [26:0] r_a [3];
    logic signed [26:0] r_c [3];
    logic signed [25:0] r_b00;
    logic [54:0]        r_f [3];
    logic signed [45:0] r_gx, r_gy;
    logic signed [63:0] r_lx, r_ly;

    logic signed [POS_W-1:0] r_px [4];
    logic signed [POS_W-1:0] r_py [4];
    logic [UNC_W-1:0]        r_pu [4];

    t_res r_res;
    logic r_valid;

    // combinational intermediates
    logic signed [7:0]  rssi_in [4];
    logic signed [8:0]  n_exp   [4];
    logic signed [8:0]  n_neg   [4];
    logic [63:0]        dist_prod [4];
    logic [31:0]        dist_rnd  [4];

    logic signed [25:0] dx0 [3];
    logic signed [25:0] dx1 [3];
    logic signed [25:0] dy0 [3];
    logic signed [25:0] dy1 [3];
    logic [24:0]        mx0 [3];
    logic [24:0]        mx1 [3];
    logic [24:0]        my0 [3];
    logic [24:0]        my1 [3];

    logic [28:0]        rem_sh [9];
    logic [28:0]        trial  [9];

    logic signed [25:0] bnd [9];
    logic signed [55:0] gx_raw, gy_raw, gx_cl, gy_cl;
    logic [53:0]        sqa [3];
    logic [53:0]        sqc [3];

    logic signed [25:0] csum_x, csum_y;
    logic [51:0]        cq_x, cq_y;

    logic [63:0]        lmag_x, lmag_y;
    logic [39:0]        lq_x, lq_y;
    logic signed [41:0] lstep_x, lstep_y, nx, ny;

    logic [25:0]        b00_mag;

    logic signed [25:0] fsum_x, fsum_y;
    logic [25:0]        fmag_x, fmag_y;
    logic [25:0]        fq_x, fq_y;
    logic [UNC_W-1:0]   umax01, umax23;
    t_res               res_n;

    always_comb begin
        rssi_in[0] = r_req.rssi_a;
        rssi_in[1] = r_req.rssi_b;
        rssi_in[2] = r_req.rssi_c;
        rssi_in[3] = r_req.rssi_d;
        if (i_cmd.op == OP_CAPTURE) begin
            rssi_in[0] = i_req.rssi_a;
            rssi_in[1] = i_req.rssi_b;
            rssi_in[2] = i_req.rssi_c;
            rssi_in[3] = i_req.rssi_d;
        end
        for (int i = 0; i < 4; i++) begin
            n_exp[i]     = RSSI_REF - 9'(rssi_in[i]);
            n_neg[i]     = -n_exp[i];
            dist_prod[i] = 64'(r_v[i]) * 64'(r_dup[i] ? K_UP : K_DOWN) + ROUND30;
            dist_rnd[i]  = dist_prod[i][61:30];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dx0[k] = 26'(r_x) - 26'(r_cx[k]);
            dx1[k] = dx0[k] + 26'sd1;
            dy0[k] = 26'(r_y) - 26'(r_cy[k]);
            dy1[k] = dy0[k] + 26'sd1;
            mx0[k] = dx0[k] < 0 ? 25'(-dx0[k]) : 25'(dx0[k]);
            mx1[k] = dx1[k] < 0 ? 25'(-dx1[k]) : 25'(dx1[k]);
            my0[k] = dy0[k] < 0 ? 25'(-dy0[k]) : 25'(dy0[k]);
            my1[k] = dy1[k] < 0 ? 25'(-dy1[k]) : 25'(dy1[k]);
        end
        for (int l = 0; l < 9; l++) begin
            rem_sh[l] = {r_rem[l], r_rad[l][49:48]};
            trial[l]  = {2'b00, r_root[l], 2'b01};
            bnd[l]    = $signed({1'b0, r_root[l]}) - $signed({3'b000, r_cd[l / 3]});
        end
        for (int p = 0; p < 3; p++) begin
            sqa[p] = 54'(r_a[p] * r_a[p]);
            sqc[p] = 54'(r_c[p] * r_c[p]);
        end
        gx_raw = $signed({1'b0, r_f[1]}) - $signed({1'b0, r_f[0]});
        gy_raw = $signed({1'b0, r_f[2]}) - $signed({1'b0, r_f[0]});
        gx_cl  = gx_raw > GCLAMP ? GCLAMP : (gx_raw < -GCLAMP ? -GCLAMP : gx_raw);
        gy_cl  = gy_raw > GCLAMP ? GCLAMP : (gy_raw < -GCLAMP ? -GCLAMP : gy_raw);

        csum_x = 26'(r_cx[0]) + 26'(r_cx[1]) + 26'(r_cx[2]);
        csum_y = 26'(r_cy[0]) + 26'(r_cy[1]) + 26'(r_cy[2]);
        cq_x   = 52'(r_cmag_x) * 52'(RECIP3);
        cq_y   = 52'(r_cmag_y) * 52'(RECIP3);

        lmag_x  = r_lx < 0 ? 64'(-r_lx) : 64'(r_lx);
        lmag_y  = r_ly < 0 ? 64'(-r_ly) : 64'(r_ly);
        lq_x    = 40'((lmag_x + ROUND24) >> 24);
        lq_y    = 40'((lmag_y + ROUND24) >> 24);
        lstep_x = r_lx < 0 ? -$signed({2'b00, lq_x}) : $signed({2'b00, lq_x});
        lstep_y = r_ly < 0 ? -$signed({2'b00, lq_y}) : $signed({2'b00, lq_y});
        nx      = 42'(r_x) - lstep_x;
        ny      = 42'(r_y) - lstep_y;

        b00_mag = r_b00 < 0 ? 26'(-r_b00) : 26'(r_b00);
    end

    always_comb begin
        fsum_x = 26'(r_px[0]) + 26'(r_px[1]) + 26'(r_px[2]) + 26'(r_px[3]);
        fsum_y = 26'(r_py[0]) + 26'(r_py[1]) + 26'(r_py[2]) + 26'(r_py[3]);
        fmag_x = fsum_x < 0 ? 26'(-fsum_x) : 26'(fsum_x);
        fmag_y = fsum_y < 0 ? 26'(-fsum_y) : 26'(fsum_y);
        fq_x   = (fmag_x + 26'd2) >> 2;
        fq_y   = (fmag_y + 26'd2) >> 2;
        umax01 = r_pu[1] > r_pu[0] ? r_pu[1] : r_pu[0];
        umax23 = r_pu[3] > r_pu[2] ? r_pu[3] : r_pu[2];

        res_n.out_id      = r_req.tag_id;
        res_n.pos_x       = '0;
        res_n.pos_y       = '0;
        res_n.uncertainty = UNC_MAX;
        res_n.fix_kind    = FIX_NONE;
        if (r_req.present_mask == 4'hF) begin
            res_n.pos_x       = fsum_x < 0 ? -$signed(fq_x[POS_W-1:0]) : $signed(fq_x[POS_W-1:0]);
            res_n.pos_y       = fsum_y < 0 ? -$signed(fq_y[POS_W-1:0]) : $signed(fq_y[POS_W-1:0]);
            res_n.uncertainty = umax23 > umax01 ? umax23 : umax01;
            res_n.fix_kind    = FIX_FUSED;
        end else if ($countones(r_req.present_mask) == 3) begin
            res_n.pos_x       = r_px[r_last];
            res_n.pos_y       = r_py[r_last];
            res_n.uncertainty = r_pu[r_last];
            res_n.fix_kind    = FIX_SINGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                r_corner_x[i] <= '0;
                r_corner_y[i] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(2 * NUM_CORNERS)) begin
                if (i_cfg_idx[0]) begin
                    r_corner_y[i_cfg_idx[2:1]] <= $signed(i_cfg_data);
                end else begin
                    r_corner_x[i_cfg_idx[2:1]] <= $signed(i_cfg_data);
                end
            end
            r_valid <= (i_cmd.op == OP_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_req <= i_req;
                for (int i = 0; i < 4; i++) begin
                    r_v[i]    <= 32'd1 << 24;
                    r_dup[i]  <= ~n_exp[i][8];
                    r_dcnt[i] <= n_exp[i][8] ? n_neg[i][7:0] : n_exp[i][7:0];
                end
            end
            OP_DIST_ITER: begin
                for (int i = 0; i < 4; i++) begin
                    if (r_dcnt[i] != 8'd0) begin
                        r_v[i]    <= dist_rnd[i];
                        r_dcnt[i] <= r_dcnt[i] - 8'd1;
                    end
                end
            end
            OP_DIST_FIN: begin
                for (int i = 0; i < 4; i++) begin
                    if (!r_req.present_mask[i]) begin
                        r_dist[i] <= '0;
                    end else if (((r_v[i] + 32'd128) >> 8) > 32'(UNC_MAX)) begin
                        r_dist[i] <= UNC_MAX;
                    end else begin
                        r_dist[i] <= DIST_W'((r_v[i] + 32'd128) >> 8);
                    end
                end
            end
            OP_TRI_LOAD: begin
                r_tri <= i_cmd.triplet;
                for (int k = 0; k < 3; k++) begin
                    r_cx[k] <= r_corner_x[2'(i_cmd.triplet + 2'(k))];
                    r_cy[k] <= r_corner_y[2'(i_cmd.triplet + 2'(k))];
                    r_cd[k] <= r_dist[2'(i_cmd.triplet + 2'(k))];
                end
            end
            OP_CENT0: begin
                r_cneg_x <= csum_x[25];
                r_cneg_y <= csum_y[25];
                r_cmag_x <= (csum_x < 0 ? 25'(-csum_x) : 25'(csum_x)) + 25'd1;
                r_cmag_y <= (csum_y < 0 ? 25'(-csum_y) : 25'(csum_y)) + 25'd1;
            end
            OP_CENT1: begin
                r_x <= r_cneg_x ? -$signed(cq_x[50:27]) : $signed(cq_x[50:27]);
                r_y <= r_cneg_y ? -$signed(cq_y[50:27]) : $signed(cq_y[50:27]);
            end
            OP_SQ: begin
                for (int k = 0; k < 3; k++) begin
                    r_sx0[k] <= 50'(mx0[k]) * 50'(mx0[k]);
                    r_sx1[k] <= 50'(mx1[k]) * 50'(mx1[k]);
                    r_sy0[k] <= 50'(my0[k]) * 50'(my0[k]);
                    r_sy1[k] <= 50'(my1[k]) * 50'(my1[k]);
                end
            end
            OP_SQRT_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    r_rad[3 * k]     <= r_sx0[k] + r_sy0[k];
                    r_rad[3 * k + 1] <= r_sx1[k] + r_sy0[k];
                    r_rad[3 * k + 2] <= r_sx0[k] + r_sy1[k];
                end
                for (int l = 0; l < 9; l++) begin
                    r_rem[l]  <= '0;
                    r_root[l] <= '0;
                end
            end
            OP_SQRT_ITER: begin
                for (int l = 0; l < 9; l++) begin
                    r_rad[l] <= r_rad[l] << 2;
                    if (rem_sh[l] >= trial[l]) begin
                        r_rem[l]  <= 27'(rem_sh[l] - trial[l]);
                        r_root[l] <= {r_root[l][23:0], 1'b1};
                    end else begin
                        r_rem[l]  <= rem_sh[l][26:0];
                        r_root[l] <= {r_root[l][23:0], 1'b0};
                    end
                end
            end
            OP_RES: begin
                r_b00 <= bnd[0];
                for (int p = 0; p < 3; p++) begin
                    r_a[p] <= 27'(bnd[p]) - 27'(bnd[3 + p]);
                    r_c[p] <= 27'(bnd[p]) - 27'(bnd[6 + p]);
                end
            end
            OP_FSQ: begin
                for (int p = 0; p < 3; p++) begin
                    r_f[p] <= 55'(sqa[p]) + 55'(sqc[p]);
                end
            end
            OP_GRAD: begin
                r_gx <= 46'(gx_cl);
                r_gy <= 46'(gy_cl);
            end
            OP_LR: begin
                r_lx <= 64'(r_gx) * LR_Q24;
                r_ly <= 64'(r_gy) * LR_Q24;
            end
            OP_UPD: begin
                r_x <= nx > SAT_HI ? POS_W'(SAT_HI) : (nx < SAT_LO ? POS_W'(SAT_LO) : POS_W'(nx));
                r_y <= ny > SAT_HI ? POS_W'(SAT_HI) : (ny < SAT_LO ? POS_W'(SAT_LO) : POS_W'(ny));
            end
            OP_SAVE: begin
                r_px[r_tri] <= r_x;
                r_py[r_tri] <= r_y;
                r_pu[r_tri] <= b00_mag > 26'(UNC_MAX) ? UNC_MAX : b00_mag[UNC_W-1:0];
                r_last      <= r_tri;
            end
            OP_EMIT: begin
                r_res <= res_n;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int t = 0; t < 4; t++) begin
            o_stat.tri_ok[t] = r_req.present_mask[t] & r_req.present_mask[2'(t + 1)]
                             & r_req.present_mask[2'(t + 2)];
        end
    end

    assign o_res   = r_res;
    assign o_valid = r_valid;

endmodule

[design/rte_ctrl.sv]
// Controller: sequences distance, centroid, descent steps, triplets and result.
module rte_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rte_pkg::t_dp_stat i_stat,
    output rte_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import rte_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_tri, n_tri;
    logic              r_final, n_final;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_tri   = r_tri;
        n_final = r_final;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DIST;
                    n_cnt   = '0;
                    n_tri   = '0;
                end
            end
            ST_DIST: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIST_ITERS - 1)) begin
                    n_state = ST_DIST_FIN;
                end
            end
            ST_DIST_FIN: n_state = ST_TRI_SEL;
            ST_TRI_SEL: begin
                if (i_stat.tri_ok[r_tri]) begin
                    n_state = ST_TRI_LOAD;
                end else if (r_tri == 2'd3) begin
                    n_state = ST_EMIT;
                end else begin
                    n_tri = r_tri + 2'd1;
                end
            end
            ST_TRI_LOAD: n_state = ST_CENT0;
            ST_CENT0:    n_state = ST_CENT1;
            ST_CENT1: begin
                n_state = ST_SQ;
                n_step  = '0;
                n_final = 1'b0;
            end
            ST_SQ: n_state = ST_SQRT_LOAD;
            ST_SQRT_LOAD: begin
                n_state = ST_SQRT_ITER;
                n_cnt   = '0;
            end
            ST_SQRT_ITER: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SQRT_ITERS - 1)) begin
                    n_state = ST_RES;
                end
            end
            ST_RES:  n_state = r_final ? ST_SAVE : ST_FSQ;
            ST_FSQ:  n_state = ST_GRAD;
            ST_GRAD: n_state = ST_LR;
            ST_LR:   n_state = ST_UPD;
            ST_UPD: begin
                n_state = ST_SQ;
                if (r_step == STEP_W'(DESCENT_STEPS - 1)) begin
                    n_final = 1'b1;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_SAVE: begin
                if (r_tri == 2'd3) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_TRI_SEL;
                    n_tri   = r_tri + 2'd1;
                end
            end
            ST_EMIT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.triplet = r_tri;
        o_busy        = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:      o_cmd.op = i_start ? OP_CAPTURE : OP_NOP;
            ST_DIST:      o_cmd.op = OP_DIST_ITER;
            ST_DIST_FIN:  o_cmd.op = OP_DIST_FIN;
            ST_TRI_LOAD:  o_cmd.op = OP_TRI_LOAD;
            ST_CENT0:     o_cmd.op = OP_CENT0;
            ST_CENT1:     o_cmd.op = OP_CENT1;
            ST_SQ:        o_cmd.op = OP_SQ;
            ST_SQRT_LOAD: o_cmd.op = OP_SQRT_LOAD;
            ST_SQRT_ITER: o_cmd.op = OP_SQRT_ITER;
            ST_RES:       o_cmd.op = OP_RES;
            ST_FSQ:       o_cmd.op = OP_FSQ;
            ST_GRAD:      o_cmd.op = OP_GRAD;
            ST_LR:        o_cmd.op = OP_LR;
            ST_UPD:       o_cmd.op = OP_UPD;
            ST_SAVE:      o_cmd.op = OP_SAVE;
            ST_EMIT:      o_cmd.op = OP_EMIT;
            default:      o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_tri   <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_tri   <= n_tri;
            r_final <= n_final;
        end
    end

`ifndef SYNTHESIS
    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without a request");
    a_sqrt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT_ITER) |-> (r_cnt < CNT_W'(SQRT_ITERS)))
        else $error("square root iteration count overrun");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_step < STEP_W'(DESCENT_STEPS)))
        else $error("descent step count overrun");
    a_save_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SAVE) |-> r_final)
        else $error("triplet saved before descent finished");
`endif

endmodule

[design/rssi_trilateration_engine.sv]
// Top level of the RSSI trilateration engine: controller plus datapath.
//
// Usage:
//   Request channel: drive i_req and pulse i_start; the request is taken at a
//   clock edge where i_start is high and o_busy is low. o_busy stays high
//   until the edge that puts the result on o_res.
//   Result channel: o_res is valid for exactly one cycle while o_valid is
//   high; the receiver cannot stall, so it must take the result then.
//   Configuration: i_cfg_we writes corner register i_cfg_idx (0..7) with
//   i_cfg_data; indexes above 7 are ignored. Write only while o_busy is low.
// Sequencing, with T the number of qualifying triplets (0, 1 or 4):
//   o_busy stays high while each of the T triplets runs its 1000 descent
//   steps, and o_valid is high in the cycle after o_busy's last high cycle.
//   Each descent step passes through the nine parallel bit-serial square
//   root lanes (25 iterations) and the multiply stages.
//   One request is processed at a time.
// Reset: synchronous active low; clears the controller and the corner
//   registers to zero and drops o_valid.
module rssi_trilateration_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  rte_pkg::t_req                  i_req,
    output logic                           o_valid,
    output rte_pkg::t_res                  o_res,
    input  logic                           i_cfg_we,
    input  logic [rte_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rte_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rte_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    rte_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_res      (o_res),
        .o_valid    (o_valid)
    );

endmodule
